// ===== rtl/sht_pkg.sv =====
// sht_pkg: shared constants, codes and payload types of the session handle table
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps
`default_nettype none

package sht_pkg;

  // table geometry
  localparam int unsigned MaxSessions = 64;
  localparam int unsigned IdxW        = $clog2(MaxSessions);
  localparam int unsigned CntW        = $clog2(MaxSessions + 1);

  // field widths
  localparam int unsigned OpW     = 3;
  localparam int unsigned StatusW = 3;
  localparam int unsigned HandleW = 7;
  localparam int unsigned SlotW   = 8;

  // operation codes
  typedef enum logic [OpW-1:0] {
    OP_OPEN      = 3'd0,
    OP_CLOSE     = 3'd1,
    OP_CLOSE_ALL = 3'd2,
    OP_LOOKUP    = 3'd3,
    OP_QUERY     = 3'd4
  } op_e;

  // status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK           = 3'd0,
    ST_SLOT_INVALID = 3'd1,
    ST_PARALLEL     = 3'd2,
    ST_NO_TOKEN     = 3'd3,
    ST_UNRECOGNIZED = 3'd4,
    ST_SO_RW_ONLY   = 3'd5,
    ST_BAD_HANDLE   = 3'd6,
    ST_FULL         = 3'd7
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_LATCH,
    S_SCAN,
    S_RESP
  } state_e;

  // request transaction
  typedef struct packed {
    logic [OpW-1:0]     operation;
    logic               slot_present;
    logic [SlotW-1:0]   slot_id;
    logic               token_present;
    logic               token_initialized;
    logic               officer_logged_in;
    logic               serial_flag;
    logic               rw_flag;
    logic [HandleW-1:0] handle_in;
  } req_t;

  // response transaction
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [HandleW-1:0] handle_out;
    logic [SlotW-1:0]   owner_slot;
    logic               is_read_write;
    logic               logout_request;
    logic               slot_has_session;
    logic               slot_has_ro_session;
  } rsp_t;

  // one stored table entry besides its valid bit
  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             rw;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/sht_if.sv =====
// sht_req_if / sht_rsp_if: valid-ready channels of the session handle table
// depends on sht_pkg for the payload types
`timescale 1ns / 1ps
`default_nettype none

interface sht_req_if;
  logic          valid;
  logic          ready;
  sht_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sht_rsp_if;
  logic          valid;
  logic          ready;
  sht_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/session_handle_table_unit.sv =====
// session_handle_table_unit: session handle table with a one-entry-a-cycle scan sequencer
// depends on sht_pkg and the channel interfaces in sht_if.sv
//
// Holds up to 64 sessions, each a valid bit (cleared by reset) plus an owner slot and a
// read-write mark kept in a single-port-read memory. One request transaction is taken at a
// time; the request side is ready whenever the sequencer is idle, and a finished response
// waits in its own output register. Rejected requests, bad handles and unused operation
// codes go straight to the response state; lookup first reads the addressed entry. Open
// scans the entries from entry 0 and stops at the lowest free one (full when none is free).
// Query and close-all walk all 64 entries; close first reads the target entry, then walks
// all 64. A stalled output register holds the sequencer in its response state until it
// frees. The scan steps through the memory's one read port one entry per cycle.
`timescale 1ns / 1ps
`default_nettype none

module session_handle_table_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  sht_req_if.sink   req_i,
  sht_rsp_if.source rsp_o
);

  localparam int unsigned IdxW = sht_pkg::IdxW;
  localparam int unsigned CntW = sht_pkg::CntW;
  localparam int unsigned Max  = sht_pkg::MaxSessions;

  // control state
  sht_pkg::state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pend_q, pend_d;
  logic            out_valid_q, out_valid_d;
  logic [Max-1:0]  valid_q, valid_d;

  // payload state
  logic [sht_pkg::OpW-1:0]   op_q, op_d;
  logic [sht_pkg::SlotW-1:0] slot_q, slot_d;
  logic                      rw_q, rw_d;
  logic [IdxW-1:0]           k_q, k_d;
  logic [IdxW-1:0]           pend_idx_q, pend_idx_d;
  logic                      found_q, found_d;
  logic                      ro_q, ro_d;
  sht_pkg::rsp_t             res_q, res_d;
  sht_pkg::rsp_t             out_q, out_d;

  // entry memory
  sht_pkg::entry_t entry_mem [Max];
  sht_pkg::entry_t rd_q;
  logic [IdxW-1:0] rd_addr;
  logic            mem_we;

  // request decode helpers
  logic [sht_pkg::HandleW-1:0] h;
  logic [IdxW-1:0]             h_idx;
  logic                        h_ok;
  logic                        ent_valid;
  logic                        ent_match;

  assign h     = req_i.data.handle_in;
  assign h_idx = IdxW'(h - sht_pkg::HandleW'(1));
  assign h_ok  = (h != '0) && (h <= sht_pkg::HandleW'(Max)) && valid_q[h_idx];

  assign ent_valid = valid_q[pend_idx_q];
  assign ent_match = ent_valid && (rd_q.slot == slot_q);

  assign req_i.ready = (state_q == sht_pkg::S_IDLE);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  // sequencer: next state and datapath control
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    valid_d     = valid_q;
    op_d        = op_q;
    slot_d      = slot_q;
    rw_d        = rw_q;
    k_d         = k_q;
    pend_idx_d  = pend_idx_q;
    found_d     = found_q;
    ro_d        = ro_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    rd_addr     = k_q;
    mem_we      = 1'b0;

    unique case (state_q)
      sht_pkg::S_IDLE: begin
        if (req_i.valid) begin
          op_d    = req_i.data.operation;
          slot_d  = req_i.data.slot_id;
          rw_d    = req_i.data.rw_flag;
          k_d     = h_idx;
          cnt_d   = '0;
          pend_d  = 1'b0;
          found_d = 1'b0;
          ro_d    = 1'b0;
          res_d   = '0;
          state_d = sht_pkg::S_RESP;
          unique case (req_i.data.operation)
            sht_pkg::OP_OPEN: begin
              priority if (!req_i.data.slot_present) begin
                res_d.status = sht_pkg::ST_SLOT_INVALID;
              end else if (!req_i.data.serial_flag) begin
                res_d.status = sht_pkg::ST_PARALLEL;
              end else if (!req_i.data.token_present) begin
                res_d.status = sht_pkg::ST_NO_TOKEN;
              end else if (!req_i.data.token_initialized) begin
                res_d.status = sht_pkg::ST_UNRECOGNIZED;
              end else if (!req_i.data.rw_flag && req_i.data.officer_logged_in) begin
                res_d.status = sht_pkg::ST_SO_RW_ONLY;
              end else begin
                state_d = sht_pkg::S_SCAN;
              end
            end
            sht_pkg::OP_CLOSE, sht_pkg::OP_LOOKUP: begin
              if (!h_ok) begin
                res_d.status = sht_pkg::ST_BAD_HANDLE;
              end else begin
                state_d = sht_pkg::S_FETCH;
              end
            end
            sht_pkg::OP_CLOSE_ALL: begin
              priority if (!req_i.data.slot_present) begin
                res_d.status = sht_pkg::ST_SLOT_INVALID;
              end else if (!req_i.data.token_present) begin
                res_d.status = sht_pkg::ST_NO_TOKEN;
              end else begin
                state_d = sht_pkg::S_SCAN;
              end
            end
            sht_pkg::OP_QUERY: begin
              state_d = sht_pkg::S_SCAN;
            end
            default: begin
              // unused codes answer with all fields zero
              state_d = sht_pkg::S_RESP;
            end
          endcase
        end
      end

      sht_pkg::S_FETCH: begin
        // read the addressed entry
        rd_addr = k_q;
        state_d = sht_pkg::S_LATCH;
      end

      sht_pkg::S_LATCH: begin
        res_d.owner_slot = rd_q.slot;
        if (op_q == sht_pkg::OP_LOOKUP) begin
          res_d.is_read_write = rd_q.rw;
          state_d = sht_pkg::S_RESP;
        end else begin
          // close: look for other sessions of the same slot
          slot_d  = rd_q.slot;
          state_d = sht_pkg::S_SCAN;
        end
      end

      sht_pkg::S_SCAN: begin
        // issue the read of the next entry
        if (cnt_q < CntW'(Max)) begin
          rd_addr    = cnt_q[IdxW-1:0];
          cnt_d      = cnt_q + CntW'(1);
          pend_d     = 1'b1;
          pend_idx_d = cnt_q[IdxW-1:0];
        end else begin
          rd_addr = k_q;
          pend_d  = 1'b0;
        end

        // evaluate the entry read in the previous cycle
        if (pend_q) begin
          unique case (op_q)
            sht_pkg::OP_OPEN: begin
              if (!ent_valid) begin
                mem_we              = 1'b1;
                valid_d[pend_idx_q] = 1'b1;
                res_d.handle_out    = sht_pkg::HandleW'(pend_idx_q) + sht_pkg::HandleW'(1);
                res_d.status        = sht_pkg::ST_OK;
                state_d             = sht_pkg::S_RESP;
              end
            end
            sht_pkg::OP_CLOSE: begin
              if (ent_match && (pend_idx_q != k_q)) begin
                found_d = 1'b1;
              end
            end
            sht_pkg::OP_CLOSE_ALL: begin
              if (ent_match) begin
                valid_d[pend_idx_q] = 1'b0;
              end
            end
            sht_pkg::OP_QUERY: begin
              if (ent_match) begin
                found_d = 1'b1;
                if (!rd_q.rw) begin
                  ro_d = 1'b1;
                end
              end
            end
            default: begin
              state_d = sht_pkg::S_RESP;
            end
          endcase
        end else if (cnt_q == CntW'(Max)) begin
          // every entry seen
          state_d = sht_pkg::S_RESP;
          unique case (op_q)
            sht_pkg::OP_OPEN: begin
              res_d.status = sht_pkg::ST_FULL;
            end
            sht_pkg::OP_CLOSE: begin
              res_d.logout_request = !found_q;
              valid_d[k_q]         = 1'b0;
            end
            sht_pkg::OP_CLOSE_ALL: begin
              res_d.logout_request = 1'b1;
            end
            sht_pkg::OP_QUERY: begin
              res_d.slot_has_session    = found_q;
              res_d.slot_has_ro_session = ro_q;
            end
            default: begin
              res_d = '0;
            end
          endcase
        end
      end

      sht_pkg::S_RESP: begin
        // hand the result to the output register once it is free
        if (!out_valid_q || rsp_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = sht_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = sht_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sht_pkg::S_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      valid_q     <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    slot_q     <= slot_d;
    rw_q       <= rw_d;
    k_q        <= k_d;
    pend_idx_q <= pend_idx_d;
    found_q    <= found_d;
    ro_q       <= ro_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[pend_idx_q] <= '{slot: slot_q, rw: rw_q};
    end
    rd_q <= entry_mem[rd_addr];
  end

  // a handle is only handed out together with an ok status
  a_handle_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.handle_out != '0)) |-> (out_q.status == sht_pkg::ST_OK))
    else $error("handle returned with a failing status");

  // an entry taken by open is marked valid right after
  a_open_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> valid_q[$past(pend_idx_q)])
    else $error("opened entry not marked valid");

  // the scan counter never runs past the table
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Max))
    else $error("scan counter beyond table depth");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// testbench: self-checking bench for session_handle_table_unit, directed rows then random traffic
// depends on sht_pkg and the request/response channel interfaces in sht_if.sv
// responses are matched in order against an in-bench model of the session table
`timescale 1ns / 1ps

module testbench;

  localparam int RandomItems = 1900;
  localparam int CycleLimit  = 1000000;
  localparam int DrainCycles = 100;
  localparam int PressureLen = 500;
  localparam int ReqW        = $bits(sht_pkg::req_t);
  localparam int OpCodes     = 1 << sht_pkg::OpW;

  // first operation code past the defined ones
  localparam logic [sht_pkg::OpW-1:0] OpUnusedFirst =
    sht_pkg::OpW'(int'(sht_pkg::OP_QUERY) + 1);
  localparam logic [sht_pkg::OpW-1:0] OpUnusedLast  = sht_pkg::OpW'(OpCodes - 1);

  // one row of the directed table
  typedef struct {
    sht_pkg::req_t req;
    bit            typed;
    sht_pkg::rsp_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  sht_req_if req_if ();
  sht_rsp_if rsp_if ();

  session_handle_table_unit DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // session table as the bench sees it
  bit                        sess_valid   [sht_pkg::MaxSessions];
  logic [sht_pkg::SlotW-1:0] sess_slot    [sht_pkg::MaxSessions];
  bit                        sess_rw      [sht_pkg::MaxSessions];
  bit                        sess_touched [sht_pkg::MaxSessions];

  sht_pkg::rsp_t awaited_responses[$];
  dir_row_t      directed_rows[$];

  int          mismatch_count = 0;
  int          rsp_seen       = 0;
  int          cycle_count    = 0;
  bit          src_quiet      = 0;
  bit          filling        = 1;
  logic [7:0]  slot_pool[4];

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d responses pending", $time, cycle_count,
               awaited_responses.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // entry index of a handle that names an open session, else -1
  function automatic int live_index(logic [sht_pkg::HandleW-1:0] h);
    if (h == 0 || h > sht_pkg::MaxSessions) return -1;
    if (!sess_valid[h-1]) return -1;
    return int'(h) - 1;
  endfunction

  // apply one request to the bench's table and return the response it must give
  function automatic sht_pkg::rsp_t apply_session_op(sht_pkg::req_t r);
    sht_pkg::rsp_t o;
    int            idx;
    int            k;
    bit            last;
    o = '0;
    case (r.operation)
      sht_pkg::OP_OPEN: begin
        if (!r.slot_present) o.status = sht_pkg::ST_SLOT_INVALID;
        else if (!r.serial_flag) o.status = sht_pkg::ST_PARALLEL;
        else if (!r.token_present) o.status = sht_pkg::ST_NO_TOKEN;
        else if (!r.token_initialized) o.status = sht_pkg::ST_UNRECOGNIZED;
        else if (!r.rw_flag && r.officer_logged_in) o.status = sht_pkg::ST_SO_RW_ONLY;
        else begin
          o.status = sht_pkg::ST_FULL;
          idx = -1;
          for (k = 0; k < sht_pkg::MaxSessions; k++)
            if (idx < 0 && !sess_valid[k]) idx = k;
          if (idx >= 0) begin
            sess_valid[idx]   = 1'b1;
            sess_slot[idx]    = r.slot_id;
            sess_rw[idx]      = r.rw_flag;
            sess_touched[idx] = 1'b1;
            o.status          = sht_pkg::ST_OK;
            o.handle_out      = sht_pkg::HandleW'(idx + 1);
          end
        end
      end
      sht_pkg::OP_CLOSE: begin
        idx = live_index(r.handle_in);
        if (idx < 0) o.status = sht_pkg::ST_BAD_HANDLE;
        else begin
          last = 1'b1;
          for (k = 0; k < sht_pkg::MaxSessions; k++)
            if (k != idx && sess_valid[k] && sess_slot[k] == sess_slot[idx]) last = 1'b0;
          o.logout_request = last;
          o.owner_slot     = sess_slot[idx];
          sess_valid[idx]  = 1'b0;
        end
      end
      sht_pkg::OP_CLOSE_ALL: begin
        if (!r.slot_present) o.status = sht_pkg::ST_SLOT_INVALID;
        else if (!r.token_present) o.status = sht_pkg::ST_NO_TOKEN;
        else begin
          for (k = 0; k < sht_pkg::MaxSessions; k++)
            if (sess_valid[k] && sess_slot[k] == r.slot_id) sess_valid[k] = 1'b0;
          o.logout_request = 1'b1;
        end
      end
      sht_pkg::OP_LOOKUP: begin
        idx = live_index(r.handle_in);
        if (idx < 0) o.status = sht_pkg::ST_BAD_HANDLE;
        else begin
          o.owner_slot    = sess_slot[idx];
          o.is_read_write = sess_rw[idx];
        end
      end
      sht_pkg::OP_QUERY: begin
        for (k = 0; k < sht_pkg::MaxSessions; k++)
          if (sess_valid[k] && sess_slot[k] == r.slot_id) begin
            o.slot_has_session = 1'b1;
            if (!sess_rw[k]) o.slot_has_ro_session = 1'b1;
          end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic sht_pkg::req_t mk_req(logic [sht_pkg::OpW-1:0] op, bit slot_ok,
                                           logic [7:0] slot, bit tok, bit init, bit officer,
                                           bit serial, bit rw,
                                           logic [sht_pkg::HandleW-1:0] h);
    sht_pkg::req_t r;
    r.operation         = op;
    r.slot_present      = slot_ok;
    r.slot_id           = slot;
    r.token_present     = tok;
    r.token_initialized = init;
    r.officer_logged_in = officer;
    r.serial_flag       = serial;
    r.rw_flag           = rw;
    r.handle_in         = h;
    return r;
  endfunction

  function automatic sht_pkg::rsp_t mk_rsp(sht_pkg::status_e st,
                                           logic [sht_pkg::HandleW-1:0] h, logic [7:0] slot,
                                           bit rw, bit logout, bit has, bit ro);
    sht_pkg::rsp_t o;
    o.status              = st;
    o.handle_out          = h;
    o.owner_slot          = slot;
    o.is_read_write       = rw;
    o.logout_request      = logout;
    o.slot_has_session    = has;
    o.slot_has_ro_session = ro;
    return o;
  endfunction

  task automatic add_row(input sht_pkg::req_t r, input bit typed, input sht_pkg::rsp_t want);
    dir_row_t row;
    row.req       = r;
    row.typed     = typed;
    row.want      = want;
    directed_rows = {directed_rows, row};
  endtask

  // slot mostly from a small shared pool so sessions collide
  function automatic logic [7:0] pick_slot();
    if ($urandom_range(99) < 90) return slot_pool[$urandom_range(3)];
    return 8'($urandom_range(255));
  endfunction

  function automatic void refresh_pool();
    slot_pool[0] = $urandom_range(1) ? 8'h00 : 8'($urandom);
    slot_pool[1] = $urandom_range(1) ? 8'hff : 8'($urandom);
    slot_pool[2] = 8'($urandom);
    slot_pool[3] = 8'($urandom);
  endfunction

  // handle of an open session, or a bad one that never names an unwritten entry
  function automatic logic [sht_pkg::HandleW-1:0] pick_handle(bit live);
    int start;
    int k;
    int h;
    h = 0;
    if (live) begin
      start = $urandom_range(sht_pkg::MaxSessions - 1);
      for (k = 0; k < sht_pkg::MaxSessions; k++)
        if (h == 0 && sess_valid[(start + k) % sht_pkg::MaxSessions])
          h = (start + k) % sht_pkg::MaxSessions + 1;
    end
    if (h == 0) begin
      h = $urandom_range(sht_pkg::MaxSessions);
      if (h != 0 && !sess_touched[h-1]) h = 0;
    end
    return sht_pkg::HandleW'(h);
  endfunction

  // operation weights, indexed by operation code
  int fill_w[5]  = '{60, 12, 12, 12, 4};
  int drain_w[5] = '{15, 50, 15, 15, 5};

  function automatic sht_pkg::op_e pick_op();
    int           roll;
    int           acc;
    int           k;
    bit           done;
    sht_pkg::op_e op;
    roll = $urandom_range(99);
    acc  = 0;
    done = 1'b0;
    op   = sht_pkg::OP_QUERY;
    for (k = 0; k < 5; k++) begin
      acc += filling ? fill_w[k] : drain_w[k];
      if (!done && roll < acc) begin
        op   = sht_pkg::op_e'(k);
        done = 1'b1;
      end
    end
    return op;
  endfunction

  function automatic sht_pkg::req_t draw_session_req();
    sht_pkg::req_t r;
    r           = sht_pkg::req_t'(ReqW'($urandom));
    r.operation = pick_op();
    // now and then an unused operation code
    if ($urandom_range(99) < 2)
      r.operation = sht_pkg::OpW'($urandom_range(OpCodes - 1, int'(OpUnusedFirst)));
    case (r.operation)
      sht_pkg::OP_OPEN: begin
        r.slot_id = pick_slot();
        if ($urandom_range(99) < 85) begin
          r.slot_present      = 1'b1;
          r.serial_flag       = 1'b1;
          r.token_present     = 1'b1;
          r.token_initialized = 1'b1;
          if (r.officer_logged_in && $urandom_range(3) != 0) r.rw_flag = 1'b1;
        end
      end
      sht_pkg::OP_CLOSE, sht_pkg::OP_LOOKUP:
        r.handle_in = pick_handle($urandom_range(99) < 85);
      sht_pkg::OP_CLOSE_ALL: begin
        r.slot_id = pick_slot();
        if ($urandom_range(99) < 85) begin
          r.slot_present  = 1'b1;
          r.token_present = 1'b1;
        end
      end
      default: r.slot_id = pick_slot();
    endcase
    return r;
  endfunction

  function automatic int pick_gap(bit quiet);
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // offer one request transaction and record its expected response on acceptance
  task automatic offer_request(input sht_pkg::req_t r, input bit typed,
                               input sht_pkg::rsp_t want);
    int            gap;
    sht_pkg::rsp_t model_rsp;
    gap = pick_gap(src_quiet);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    model_rsp = apply_session_op(r);
    if (typed) model_rsp = want;
    awaited_responses = {awaited_responses, model_rsp};
  endtask

  function automatic void cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // response checker
  always @(posedge clk) begin
    sht_pkg::rsp_t want;
    sht_pkg::rsp_t got;
    if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got      = rsp_if.data;
      rsp_seen = rsp_seen + 1;
      if (awaited_responses.size() == 0) begin
        mismatch_count++;
        $display("%0t: response with none expected, expected nothing, got %p", $time, got);
      end else begin
        want = awaited_responses.pop_front();
        cmp_field("status", 8'(want.status), 8'(got.status));
        cmp_field("handle_out", 8'(want.handle_out), 8'(got.handle_out));
        cmp_field("owner_slot", want.owner_slot, got.owner_slot);
        cmp_field("is_read_write", 8'(want.is_read_write), 8'(got.is_read_write));
        cmp_field("logout_request", 8'(want.logout_request), 8'(got.logout_request));
        cmp_field("slot_has_session", 8'(want.slot_has_session), 8'(got.slot_has_session));
        cmp_field("slot_has_ro_session", 8'(want.slot_has_ro_session),
                  8'(got.slot_has_ro_session));
      end
    end
  end

  // response side: random stalls, quiet stretches and long hold-offs
  initial begin
    int  hold;
    int  pressure_mark;
    int  mode_mark;
    bit  quiet;
    hold          = 0;
    pressure_mark = 300;
    mode_mark     = 100;
    quiet         = 0;
    rsp_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (rsp_seen >= mode_mark) begin
        quiet     = ($urandom_range(3) == 0);
        mode_mark = mode_mark + 100;
      end
      if (rsp_seen >= pressure_mark) begin
        hold          = PressureLen;
        pressure_mark = pressure_mark + 900;
      end
      if (hold > 0) begin
        hold--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!quiet && $urandom_range(99) < 25) begin
          case ($urandom_range(19))
            0:       hold = $urandom_range(10, 40);
            1, 2, 3: hold = $urandom_range(4, 8);
            default: hold = $urandom_range(1, 3);
          endcase
        end
      end
    end
  end

  // reset, directed table, random traffic, drain
  initial begin
    int            i;
    int            phase_end;
    sht_pkg::req_t r;
    rst_n        <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    refresh_pool();

    // after reset: a query, open rejects in check order, opens, unused codes, lookups, closes, close-all
    add_row(mk_req(sht_pkg::OP_QUERY, 0, 8'h00, 0, 0, 0, 0, 0, 0), 1,
            mk_rsp(sht_pkg::ST_OK, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(sht_pkg::OP_OPEN, 0, 8'hff, 1, 1, 1, 1, 1, 64), 1,
            mk_rsp(sht_pkg::ST_SLOT_INVALID, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(sht_pkg::OP_OPEN, 1, 8'h12, 1, 1, 0, 0, 1, 0), 1,
            mk_rsp(sht_pkg::ST_PARALLEL, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(sht_pkg::OP_OPEN, 1, 8'h12, 0, 1, 0, 1, 1, 0), 1,
            mk_rsp(sht_pkg::ST_NO_TOKEN, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(sht_pkg::OP_OPEN, 1, 8'h12, 1, 0, 0, 1, 1, 0), 1,
            mk_rsp(sht_pkg::ST_UNRECOGNIZED, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(sht_pkg::OP_OPEN, 1, 8'h12, 1, 1, 1, 1, 0, 0), 1,
            mk_rsp(sht_pkg::ST_SO_RW_ONLY, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(sht_pkg::OP_OPEN, 1, 8'h00, 1, 1, 1, 1, 1, 0), 1,
            mk_rsp(sht_pkg::ST_OK, 1, 0, 0, 0, 0, 0));
    add_row(mk_req(sht_pkg::OP_OPEN, 1, 8'hff, 1, 1, 0, 1, 0, 64), 1,
            mk_rsp(sht_pkg::ST_OK, 2, 0, 0, 0, 0, 0));
    add_row(mk_req(sht_pkg::OP_OPEN, 1, 8'hff, 1, 1, 1, 1, 1, 64), 1,
            mk_rsp(sht_pkg::ST_OK, 3, 0, 0, 0, 0, 0));
    add_row(mk_req(OpUnusedFirst, 1, 8'hff, 1, 1, 1, 1, 1, 1), 1,
            mk_rsp(sht_pkg::ST_OK, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(OpUnusedLast, 1, 8'h00, 1, 1, 1, 1, 1, 2), 1,
            mk_rsp(sht_pkg::ST_OK, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(sht_pkg::OP_LOOKUP, 1, 8'hff, 1, 1, 1, 1, 1, 0), 1,
            mk_rsp(sht_pkg::ST_BAD_HANDLE, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(sht_pkg::OP_LOOKUP, 1, 8'hff, 1, 1, 1, 1, 1, 64), 1,
            mk_rsp(sht_pkg::ST_BAD_HANDLE, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(sht_pkg::OP_CLOSE, 0, 8'h00, 0, 0, 0, 0, 0, 0), 1,
            mk_rsp(sht_pkg::ST_BAD_HANDLE, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(sht_pkg::OP_LOOKUP, 0, 8'h00, 0, 0, 0, 0, 0, 2), 0, '0);
    add_row(mk_req(sht_pkg::OP_QUERY, 1, 8'hff, 1, 1, 1, 1, 1, 0), 0, '0);
    add_row(mk_req(sht_pkg::OP_LOOKUP, 1, 8'h55, 1, 1, 1, 1, 1, 1), 0, '0);
    add_row(mk_req(sht_pkg::OP_CLOSE, 1, 8'h00, 1, 1, 1, 1, 1, 2), 0, '0);
    add_row(mk_req(sht_pkg::OP_CLOSE, 1, 8'hff, 1, 1, 1, 1, 1, 2), 1,
            mk_rsp(sht_pkg::ST_BAD_HANDLE, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(sht_pkg::OP_OPEN, 1, 8'hff, 1, 1, 0, 1, 0, 0), 0, '0);
    add_row(mk_req(sht_pkg::OP_CLOSE_ALL, 0, 8'hff, 1, 1, 1, 1, 1, 0), 1,
            mk_rsp(sht_pkg::ST_SLOT_INVALID, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(sht_pkg::OP_CLOSE_ALL, 1, 8'hff, 0, 1, 1, 1, 1, 0), 1,
            mk_rsp(sht_pkg::ST_NO_TOKEN, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(sht_pkg::OP_CLOSE_ALL, 1, 8'hff, 1, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk_req(sht_pkg::OP_CLOSE_ALL, 1, 8'hc8, 1, 1, 1, 1, 1, 0), 1,
            mk_rsp(sht_pkg::ST_OK, 0, 0, 0, 1, 0, 0));
    add_row(mk_req(sht_pkg::OP_QUERY, 1, 8'hff, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk_req(sht_pkg::OP_CLOSE, 0, 8'hff, 0, 0, 0, 0, 0, 1), 0, '0);
    add_row(mk_req(sht_pkg::OP_QUERY, 0, 8'h00, 1, 1, 1, 1, 1, 64), 0, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[n])
      offer_request(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].want);

    // random part: alternating fill and drain phases reach a full and an empty table
    phase_end = $urandom_range(150, 250);
    for (i = 0; i < RandomItems; i++) begin
      if (i % 100 == 0) src_quiet = ($urandom_range(3) == 0);
      if (i == phase_end) begin
        filling   = !filling;
        phase_end = i + $urandom_range(150, 250);
        refresh_pool();
      end
      r = draw_session_req();
      offer_request(r, 1'b0, '0);
    end
    req_if.valid <= 1'b0;

    // wait out every response, then a quiet window for strays
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
